FILE: design/wcs_pkg.sv
// wcs_pkg: shared types and constants of the crossfade splice block
// used by wcs_front, wcs_queue, wcs_back and waveform_crossfade_splice
package wcs_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_CH_W    = 4;
  localparam int CFG_FRAME_W = 24;
  localparam int DEN_W       = CFG_FRAME_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_FRAMES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDIT_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDIT_END      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_FRAMES   = 3'd4;

  localparam int RAMP_PAD             = 1;
  localparam int W_FRAC               = 16;
  localparam int W_W                  = W_FRAC + 1;
  localparam logic [W_W-1:0] WEIGHT_ONE = {1'b1, {W_FRAC{1'b0}}};
  localparam int RND_BIAS             = 1 << (W_FRAC - 1);

  localparam int SETTLE_CYCLES = 3;
  localparam int SETTLE_W      = 2;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    REG_OUTSIDE,
    REG_INSIDE,
    REG_LEFT,
    REG_RIGHT
  } region_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUM
  } back_state_e;

  typedef struct packed {
    logic             last;
    logic             past;
    region_e          region;
    logic [DEN_W-1:0] num;
    logic [DEN_W-1:0] den;
  } job_t;

endpackage

FILE: design/waveform_crossfade_splice.sv
// waveform_crossfade_splice: top level of the crossfade splice block
// depends on wcs_pkg, wcs_front, wcs_queue and wcs_back
//
// Splices a generated track into a source track, one interleaved channel value per
// transfer, with linear Q0.16 ramps of up to fade_frames frames on each side of the
// clamped edit window; every input transfer gives exactly one result transfer. The
// front accepts one item a cycle while its two-entry queue has room and no
// configuration write is settling. The back takes one item at a time: load, a divide
// for ramp items (a serial divider makes one weight bit a cycle), multiply, then
// round and saturate into the result register once the previous result is popped.
// After any configuration write, full stays high while the window bounds settle.
module waveform_crossfade_splice #(
  parameter int MAX_CHANNELS     = 8,
  parameter int SAMPLE_BITS      = 16,
  parameter int FRAME_COUNT_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wcs_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [wcs_pkg::CFG_FRAME_W-1:0] cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic signed [SAMPLE_BITS-1:0]   gen_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]   src_sample_i,
  input  logic                            last_of_clip_i,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [SAMPLE_BITS-1:0]   spliced_sample_o,
  output logic                            past_end_o,
  output logic                            end_of_clip_o
);
  import wcs_pkg::*;

  localparam int JOB_W = $bits(job_t);
  localparam int ENT_W = 2 * SAMPLE_BITS + JOB_W;

  job_t                          front_job, back_job;
  logic                          q_push, q_pop, q_full, q_empty;
  logic [ENT_W-1:0]              q_wdata, q_rdata;
  logic signed [SAMPLE_BITS-1:0] q_gen, q_src;

  wcs_front #(
    .MAX_CHANNELS     (MAX_CHANNELS),
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .last_i      (last_of_clip_i),
    .q_full_i    (q_full),
    .full_o      (full),
    .q_push_o    (q_push),
    .job_o       (front_job)
  );

  assign q_wdata = {gen_sample_i, src_sample_i, front_job};

  wcs_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign q_gen    = $signed(q_rdata[ENT_W-1 -: SAMPLE_BITS]);
  assign q_src    = $signed(q_rdata[JOB_W +: SAMPLE_BITS]);
  assign back_job = q_rdata[JOB_W-1:0];

  wcs_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .gen_i            (q_gen),
    .src_i            (q_src),
    .job_i            (back_job),
    .out_pop_i        (pop),
    .out_empty_o      (empty),
    .spliced_sample_o (spliced_sample_o),
    .past_end_o       (past_end_o),
    .end_of_clip_o    (end_of_clip_o)
  );

endmodule

FILE: design/wcs_front.sv
// wcs_front: configuration registers, window bounds, position counters and item classification
// depends on wcs_pkg
module wcs_front #(
  parameter int MAX_CHANNELS     = 8,
  parameter int FRAME_COUNT_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wcs_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [wcs_pkg::CFG_FRAME_W-1:0]     cfg_wdata_i,
  input  logic                                push_i,
  input  logic                                last_i,
  input  logic                                q_full_i,
  output logic                                full_o,
  output logic                                q_push_o,
  output wcs_pkg::job_t                       job_o
);
  import wcs_pkg::*;

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CMP_W = (CH_W + 1 > CFG_CH_W) ? CH_W + 1 : CFG_CH_W;
  localparam int FW    = FRAME_COUNT_BITS;
  localparam int XW    = (FW > DEN_W) ? FW : DEN_W;

  logic [CFG_CH_W-1:0]    ch_count_q;
  logic [CFG_FRAME_W-1:0] clip_q, edit_start_q, edit_end_q, fade_q;
  logic [CFG_FRAME_W-1:0] es_q, ee_q, fs_q, fe_q;
  logic [CFG_FRAME_W-1:0] es_d, ee_d, fs_d, fe_d;
  logic [CFG_FRAME_W:0]   fe_sum;
  logic [DEN_W-1:0]       dl_q, dr_q, dl_d, dr_d;
  logic [SETTLE_W-1:0]    settle_q;
  logic [CH_W-1:0]        chan_q;
  logic [FW-1:0]          frame_q;
  logic [CMP_W-1:0]       ch_eff, ch_cfg;
  logic                   chan_wrap;
  logic [XW-1:0]          f_x, s_x, es_x, ee_x, fs_x, fe_x;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_count_q   <= CFG_CH_W'(1);
      clip_q       <= CFG_FRAME_W'(1);
      edit_start_q <= '0;
      edit_end_q   <= '0;
      fade_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_CHANNEL_COUNT: ch_count_q   <= cfg_wdata_i[CFG_CH_W-1:0];
        CFG_CLIP_FRAMES:   clip_q       <= cfg_wdata_i;
        CFG_EDIT_START:    edit_start_q <= cfg_wdata_i;
        CFG_EDIT_END:      edit_end_q   <= cfg_wdata_i;
        CFG_FADE_FRAMES:   fade_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // window bounds, settled over three stages
  always_comb begin
    es_d = (edit_start_q < clip_q) ? edit_start_q : clip_q;
    if (edit_end_q < es_d) begin
      ee_d = es_d;
    end else if (edit_end_q > clip_q) begin
      ee_d = clip_q;
    end else begin
      ee_d = edit_end_q;
    end
    fs_d   = (es_q > fade_q) ? es_q - fade_q : '0;
    fe_sum = {1'b0, ee_q} + {1'b0, fade_q};
    fe_d   = (fe_sum > {1'b0, clip_q}) ? clip_q : fe_sum[CFG_FRAME_W-1:0];
    dl_d   = {1'b0, es_q} - {1'b0, fs_q} + DEN_W'(RAMP_PAD);
    dr_d   = {1'b0, fe_q} - {1'b0, ee_q} + DEN_W'(RAMP_PAD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q     <= '0;
      ee_q     <= '0;
      fs_q     <= '0;
      fe_q     <= '0;
      dl_q     <= DEN_W'(RAMP_PAD);
      dr_q     <= DEN_W'(RAMP_PAD);
      settle_q <= '0;
    end else begin
      es_q <= es_d;
      ee_q <= ee_d;
      fs_q <= fs_d;
      fe_q <= fe_d;
      dl_q <= dl_d;
      dr_q <= dr_d;
      if (cfg_we_i) begin
        settle_q <= SETTLE_W'(SETTLE_CYCLES);
      end else if (settle_q != '0) begin
        settle_q <= settle_q - SETTLE_W'(1);
      end
    end
  end

  assign full_o   = q_full_i || (settle_q != '0);
  assign q_push_o = push_i && !full_o;

  // position counters
  always_comb begin
    ch_cfg = CMP_W'(ch_count_q);
    if (ch_cfg == '0) begin
      ch_eff = CMP_W'(1);
    end else if (ch_cfg > CMP_W'(MAX_CHANNELS)) begin
      ch_eff = CMP_W'(MAX_CHANNELS);
    end else begin
      ch_eff = ch_cfg;
    end
    chan_wrap = (CMP_W'(chan_q) + CMP_W'(1)) >= ch_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q  <= '0;
      frame_q <= '0;
    end else if (q_push_o) begin
      if (last_i) begin
        chan_q  <= '0;
        frame_q <= '0;
      end else if (chan_wrap) begin
        chan_q <= '0;
        if (frame_q != '1) begin
          frame_q <= frame_q + FW'(1);
        end
      end else begin
        chan_q <= chan_q + CH_W'(1);
      end
    end
  end

  // classification of the current frame
  always_comb begin
    f_x  = XW'(frame_q);
    s_x  = XW'(clip_q);
    es_x = XW'(es_q);
    ee_x = XW'(ee_q);
    fs_x = XW'(fs_q);
    fe_x = XW'(fe_q);
    job_o.last   = last_i;
    job_o.past   = f_x >= s_x;
    job_o.region = REG_OUTSIDE;
    job_o.num    = '0;
    job_o.den    = dl_q;
    priority if (f_x >= es_x && f_x < ee_x) begin
      job_o.region = REG_INSIDE;
    end else if (f_x >= fs_x && f_x < es_x) begin
      job_o.region = REG_LEFT;
      job_o.num    = DEN_W'(f_x - fs_x + XW'(RAMP_PAD));
      job_o.den    = dl_q;
    end else if (f_x >= ee_x && f_x < fe_x) begin
      job_o.region = REG_RIGHT;
      job_o.num    = DEN_W'(fe_x - f_x);
      job_o.den    = dr_q;
    end else begin
      job_o.region = REG_OUTSIDE;
    end
  end

endmodule

FILE: design/wcs_queue.sv
// wcs_queue: short register queue between the front and back parts
// depends on wcs_pkg
module wcs_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);
  import wcs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

FILE: design/wcs_back.sv
// wcs_back: ramp weight divider, blend multiplier, rounding, saturation and result register
// depends on wcs_pkg
module wcs_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  input  logic signed [SAMPLE_BITS-1:0] gen_i,
  input  logic signed [SAMPLE_BITS-1:0] src_i,
  input  wcs_pkg::job_t                 job_i,
  input  logic                          out_pop_i,
  output logic                          out_empty_o,
  output logic signed [SAMPLE_BITS-1:0] spliced_sample_o,
  output logic                          past_end_o,
  output logic                          end_of_clip_o
);
  import wcs_pkg::*;

  localparam int STEP_W = $clog2(W_FRAC);
  localparam int DW     = SAMPLE_BITS + 1;
  localparam int PW     = SAMPLE_BITS + W_W + 2;
  localparam int AW     = PW + 1;
  localparam int RW     = AW - W_FRAC;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  back_state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] gen_q, src_q;
  logic signed [DW-1:0]          diff_q;
  logic                          last_q, past_q;
  logic [DEN_W-1:0]              rem_q, den_q, rem_next;
  logic [DEN_W:0]                rem_dbl;
  logic                          quot_bit;
  logic [W_FRAC-1:0]             quot_q;
  logic [STEP_W-1:0]             step_q;
  logic [W_W-1:0]                w_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [AW-1:0]          acc;
  logic signed [RW-1:0]          res;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          out_valid_q, out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (job_i.region == REG_LEFT || job_i.region == REG_RIGHT) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        if (step_q == '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_SUM;
      ST_SUM: begin
        if (!out_valid_q || out_pop_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // restoring divide, one weight bit a cycle
  always_comb begin
    rem_dbl  = {rem_q, 1'b0};
    quot_bit = rem_dbl >= {1'b0, den_q};
    rem_next = quot_bit ? DEN_W'(rem_dbl - {1'b0, den_q}) : rem_dbl[DEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      gen_q  <= gen_i;
      src_q  <= src_i;
      diff_q <= DW'(gen_i) - DW'(src_i);
      last_q <= job_i.last;
      past_q <= job_i.past;
      rem_q  <= job_i.num;
      den_q  <= job_i.den;
      quot_q <= '0;
      step_q <= STEP_W'(W_FRAC - 1);
      w_q    <= (job_i.region == REG_INSIDE) ? WEIGHT_ONE : '0;
    end else if (state_q == ST_DIV) begin
      rem_q  <= rem_next;
      quot_q <= {quot_q[W_FRAC-2:0], quot_bit};
      step_q <= step_q - STEP_W'(1);
      if (step_q == '0) begin
        w_q <= {1'b0, quot_q[W_FRAC-2:0], quot_bit};
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= $signed({1'b0, w_q}) * diff_q;
    end
  end

  // round half up and saturate
  always_comb begin
    acc = (AW'(src_q) <<< W_FRAC) + AW'(prod_q) + AW'(RND_BIAS);
    res = $signed(acc[AW-1:W_FRAC]);
    if (res > RW'(S_MAX)) begin
      sat = S_MAX;
    end else if (res < RW'(S_MIN)) begin
      sat = S_MIN;
    end else begin
      sat = res[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      spliced_sample_o <= past_q ? gen_q : sat;
      past_end_o       <= past_q;
      end_of_clip_o    <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_empty_o = !out_valid_q;

endmodule

FILE: tb/wcs_splice_checker.sv
// wcs_splice_checker: predicts each spliced result and compares it with the block output
// watches the config, input and result channels of waveform_crossfade_splice; uses wcs_pkg
module wcs_splice_checker #(
  parameter int MAX_CHANNELS     = 8,
  parameter int SAMPLE_BITS      = 16,
  parameter int FRAME_COUNT_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wcs_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [wcs_pkg::CFG_FRAME_W-1:0] cfg_wdata_i,
  input  logic                            push_i,
  input  logic                            full_i,
  input  logic signed [SAMPLE_BITS-1:0]   gen_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]   src_sample_i,
  input  logic                            last_of_clip_i,
  input  logic                            empty_i,
  input  logic                            pop_i,
  input  logic signed [SAMPLE_BITS-1:0]   spliced_sample_i,
  input  logic                            past_end_i,
  input  logic                            end_of_clip_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import wcs_pkg::*;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   past;
    logic                   eoc;
  } splice_out_t;

  localparam longint UNITY      = longint'(1) << W_FRAC;
  localparam longint FRAME_MAX  = (longint'(1) << FRAME_COUNT_BITS) - 1;
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_BITS - 1));

  logic [CFG_CH_W-1:0]    chan_cfg;
  logic [CFG_FRAME_W-1:0] clip_cfg;
  logic [CFG_FRAME_W-1:0] start_cfg;
  logic [CFG_FRAME_W-1:0] end_cfg;
  logic [CFG_FRAME_W-1:0] fade_cfg;
  longint                 frame_pos;
  int                     chan_pos;
  splice_out_t            splice_q[$];
  splice_out_t            want;
  splice_out_t            have;
  longint                 w;
  longint                 acc;
  longint                 blended;
  int                     ch_eff;
  int                     result_no;
  int                     fail_total = 0;
  int                     pending_total = 0;

  assign fail_count_o = fail_total;
  assign pending_o    = pending_total;

  task automatic report_mismatch(input string msg);
    $display("wcs_splice_checker: mismatch: %s", msg);
    fail_total++;
  endtask

  // Q1.16 weight of the generated track at frame f
  function automatic longint ramp_weight(input longint f);
    longint s, es, ee, fs, fe, d;
    s  = clip_cfg;
    d  = fade_cfg;
    es = (start_cfg < clip_cfg) ? longint'(start_cfg) : s;
    ee = end_cfg;
    if (ee < es) ee = es;
    if (ee > s) ee = s;
    if (f >= es && f < ee) return UNITY;
    if (d > 0) begin
      fs = (es > d) ? es - d : 0;
      fe = ee + d;
      if (fe > s) fe = s;
      if (f >= fs && f < es)
        return ((f - fs + RAMP_PAD) * UNITY) / (es - fs + RAMP_PAD);
      if (f >= ee && f < fe)
        return ((fe - f) * UNITY) / (fe - ee + RAMP_PAD);
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cfg  = CFG_CH_W'(1);
      clip_cfg  = CFG_FRAME_W'(1);
      start_cfg = '0;
      end_cfg   = '0;
      fade_cfg  = '0;
      frame_pos = 0;
      chan_pos  = 0;
      result_no = 0;
      splice_q.delete();
      pending_total = 0;
    end else begin
      if (pop_i && !empty_i) begin
        have = '{sample: spliced_sample_i, past: past_end_i, eoc: end_of_clip_i};
        if (splice_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected (sample %0d)",
                                    result_no, spliced_sample_i));
        end else begin
          want = splice_q.pop_front();
          if (have.sample !== want.sample)
            report_mismatch($sformatf("result %0d spliced_sample %0d, expected %0d", result_no,
                                      $signed(have.sample), $signed(want.sample)));
          if (have.past !== want.past)
            report_mismatch($sformatf("result %0d past_end %b, expected %b", result_no,
                                      have.past, want.past));
          if (have.eoc !== want.eoc)
            report_mismatch($sformatf("result %0d end_of_clip %b, expected %b", result_no,
                                      have.eoc, want.eoc));
        end
        result_no++;
      end

      if (push_i && !full_i) begin
        want.eoc  = last_of_clip_i;
        want.past = (frame_pos >= longint'(clip_cfg));
        if (want.past) begin
          want.sample = gen_sample_i;
        end else begin
          w       = ramp_weight(frame_pos);
          acc     = w * longint'(gen_sample_i) + (UNITY - w) * longint'(src_sample_i);
          blended = (acc + (UNITY >>> 1)) >>> W_FRAC;
          if (blended > SAMPLE_MAX) blended = SAMPLE_MAX;
          if (blended < SAMPLE_MIN) blended = SAMPLE_MIN;
          want.sample = blended[SAMPLE_BITS-1:0];
        end
        splice_q = {splice_q, want};

        ch_eff = chan_cfg;
        if (ch_eff < 1) ch_eff = 1;
        if (ch_eff > MAX_CHANNELS) ch_eff = MAX_CHANNELS;
        if (last_of_clip_i) begin
          frame_pos = 0;
          chan_pos  = 0;
        end else if (chan_pos + 1 >= ch_eff) begin
          chan_pos = 0;
          if (frame_pos < FRAME_MAX) frame_pos++;
        end else begin
          chan_pos++;
        end
      end

      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_CHANNEL_COUNT: chan_cfg  = cfg_wdata_i[CFG_CH_W-1:0];
          CFG_CLIP_FRAMES:   clip_cfg  = cfg_wdata_i;
          CFG_EDIT_START:    start_cfg = cfg_wdata_i;
          CFG_EDIT_END:      end_cfg   = cfg_wdata_i;
          CFG_FADE_FRAMES:   fade_cfg  = cfg_wdata_i;
          default: ;
        endcase
      end

      pending_total = splice_q.size();
    end
  end

endmodule

FILE: tb/waveform_crossfade_splice_tb.sv
// waveform_crossfade_splice_tb: stimulus and verdict for the crossfade splice block
// drives clips of interleaved samples under many window settings; needs wcs_pkg,
// waveform_crossfade_splice and wcs_splice_checker
module waveform_crossfade_splice_tb;
  import wcs_pkg::*;

  localparam int MAX_CHANNELS     = 8;
  localparam int SAMPLE_BITS      = 16;
  localparam int FRAME_COUNT_BITS = 24;
  localparam int DRAIN_CYCLES     = 40;
  localparam int MAX_GAP          = 12;
  localparam int ITEM_TARGET      = 850;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_addr;
  logic [CFG_FRAME_W-1:0]        cfg_wdata;
  logic                          push;
  logic                          full;
  logic signed [SAMPLE_BITS-1:0] gen_sample;
  logic signed [SAMPLE_BITS-1:0] src_sample;
  logic                          last_of_clip;
  logic                          empty;
  logic                          pop;
  logic signed [SAMPLE_BITS-1:0] spliced_sample;
  logic                          past_end;
  logic                          end_of_clip;
  int                            fail_count;
  int                            pending;

  bit burst;
  int ch_eff;
  int items_sent;

  waveform_crossfade_splice #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .push            (push),
    .full            (full),
    .gen_sample_i    (gen_sample),
    .src_sample_i    (src_sample),
    .last_of_clip_i  (last_of_clip),
    .empty           (empty),
    .pop             (pop),
    .spliced_sample_o(spliced_sample),
    .past_end_o      (past_end),
    .end_of_clip_o   (end_of_clip)
  );

  wcs_splice_checker #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .push_i          (push),
    .full_i          (full),
    .gen_sample_i    (gen_sample),
    .src_sample_i    (src_sample),
    .last_of_clip_i  (last_of_clip),
    .empty_i         (empty),
    .pop_i           (pop),
    .spliced_sample_i(spliced_sample),
    .past_end_i      (past_end),
    .end_of_clip_i   (end_of_clip),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("waveform_crossfade_splice_tb: FAIL");
    $finish;
  end

  // result side: random stall before each transfer
  initial begin : result_drain
    int gap;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int frame_bound(input int hi);
    if ($urandom_range(0, 7) == 0) return 24'hFFFFFF;
    return $urandom_range(0, hi);
  endfunction

  task automatic send_item(input logic [SAMPLE_BITS-1:0] g, input logic [SAMPLE_BITS-1:0] s,
                           input logic l);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push         <= 1'b1;
    gen_sample   <= g;
    src_sample   <= s;
    last_of_clip <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_FRAME_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input int ch, input int clip, input int es, input int ee,
                               input int fade);
    logic [CFG_IDX_W-1:0] spare_idx;
    spare_idx = CFG_IDX_W'(CFG_FADE_FRAMES + 1 + $urandom_range(0, 2));
    write_reg(CFG_CHANNEL_COUNT, {20'($urandom), 4'(ch)});
    write_reg(CFG_CLIP_FRAMES, 24'(clip));
    write_reg(CFG_EDIT_START, 24'(es));
    write_reg(CFG_EDIT_END, 24'(ee));
    write_reg(CFG_FADE_FRAMES, 24'(fade));
    write_reg(spare_idx, 24'($urandom));
    cfg_we <= 1'b0;
    ch_eff = ch & 4'hF;
    if (ch_eff < 1) ch_eff = 1;
    if (ch_eff > MAX_CHANNELS) ch_eff = MAX_CHANNELS;
  endtask

  // mode 0: marker on the final value, 1: marker early, 2: no marker
  task automatic send_clip(input int frames, input int mode);
    int n, stop_k;
    n = frames * ch_eff;
    if (n < 1) n = 1;
    stop_k = (mode == 1) ? $urandom_range(0, n - 1) : n - 1;
    for (int k = 0; k <= stop_k; k++)
      send_item(pick_sample(), pick_sample(), (mode != 2) && (k == stop_k));
  endtask

  // hold off the sender until every result has come back
  task automatic settle_idle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int clip;
    int mode;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    push         = 1'b0;
    gen_sample   = '0;
    src_sample   = '0;
    last_of_clip = 1'b0;
    burst        = 1'b0;
    ch_eff       = 1;
    items_sent   = 0;
    rst_ni       = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one frame from source, then past the clip
    send_item(16'h7FFF, 16'h8000, 1'b0);
    send_item(16'h8000, 16'h7FFF, 1'b0);
    send_item(16'h1234, 16'hFEDC, 1'b1);

    // two ramps around a short window, extremes of both tracks
    settle_idle();
    apply_setting(2, 6, 2, 4, 2);
    for (int k = 0; k < 14; k++)
      send_item(k[1] ? 16'h8000 : 16'h7FFF, k[1] ? 16'h7FFF : 16'h8000, k == 13);

    // zero clip length, channel count of zero, bounds out of order
    settle_idle();
    apply_setting(0, 0, 5, 3, 0);
    send_item(16'h8000, 16'h7FFF, 1'b0);
    send_item(16'h7FFF, 16'h0001, 1'b0);
    send_item(16'hFFFF, 16'h8000, 1'b1);

    // largest register values, channel count above the maximum
    settle_idle();
    apply_setting(15, 24'hFFFFFF, 24'hFFFFFF, 0, 24'hFFFFFF);
    send_clip(1, 0);

    while (items_sent < ITEM_TARGET) begin
      settle_idle();
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        apply_setting($urandom_range(0, 15), 24'hFFFFFF, frame_bound(20), frame_bound(20),
                      frame_bound(20));
        send_clip($urandom_range(1, 12), $urandom_range(0, 2));
      end else begin
        clip = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        apply_setting($urandom_range(0, 15), clip, frame_bound(clip + 4), frame_bound(clip + 4),
                      ($urandom_range(0, 3) == 0) ? 0 : frame_bound(clip + 4));
        repeat ($urandom_range(1, 2)) begin
          mode = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
          send_clip(clip + $urandom_range(0, 2), mode);
        end
      end
    end

    settle_idle();
    if (fail_count == 0) begin
      $display("waveform_crossfade_splice_tb: PASS");
    end else begin
      $display("waveform_crossfade_splice_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/wcs_pkg.sv
design/wcs_front.sv
design/wcs_queue.sv
design/wcs_back.sv
design/waveform_crossfade_splice.sv
tb/wcs_splice_checker.sv
tb/waveform_crossfade_splice_tb.sv
